// ===== design/acfd_pkg.sv =====
// Shared types and constants of the ASCII frame deframer.
package acfd_pkg;

  // Store index width, wide enough for the largest store (payload plus two tail characters).
  localparam int unsigned IDX_W = 7;

  // Codes at or above this value are never delivered.
  localparam logic [7:0] NUM_CODES = 8'd8;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVF   = 2'd2
  } status_e;

  // One finished frame, waiting for the back end.
  typedef struct packed {
    logic             bank;
    logic [2:0]       code;
    status_e          kind;
    logic             hex;
    logic [IDX_W-1:0] len;
  } job_t;

  // Payload store write from the front end.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

endpackage

// ===== design/acfd_front.sv =====
// Front end: header/tail matching, code accumulation and payload capture.
module acfd_front #(
  parameter int unsigned StoreDepth = 66
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        enabled_codes_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output acfd_pkg::job_t    job_o,
  output acfd_pkg::wr_t     wr_o
);
  import acfd_pkg::*;

  localparam int unsigned CntW = $clog2(StoreDepth + 1);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_CODE = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  typedef struct packed {
    logic       done;
    logic [1:0] prog;
  } match_t;

  function automatic match_t match3(logic [1:0] prog, logic [7:0] c, logic [7:0] mark);
    match_t m;
    m.done = 1'b0;
    m.prog = 2'd0;
    if (prog == 2'd2 && c == mark) begin
      m.done = 1'b1;
    end else if (prog == 2'd1 && c == CH_STAR) begin
      m.prog = 2'd2;
    end else if (c == mark) begin
      m.prog = 2'd1;
    end
    return m;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LC_A && c <= CH_LC_F) ||
           (c >= CH_UC_A && c <= CH_UC_F);
  endfunction

  phase_e         phase_q, phase_d;
  logic [1:0]     hdr_q, hdr_d;
  logic [1:0]     tail_q, tail_d;
  logic [7:0]     code_q, code_d;
  logic           hex_q, hex_d;
  logic [CntW-1:0] count_q, count_d;
  logic           ovf_q, ovf_d;
  logic           bank_q, bank_d;

  logic   accept;
  match_t hdr_m, tail_m;
  logic [7:0] code_times_ten;
  logic       code_ok;
  logic [CntW-1:0] len_cnt;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_stall_o = queue_full_i;

  assign hdr_m  = match3(hdr_q, rx_byte_i, CH_DOLLAR);
  assign tail_m = match3(tail_q, rx_byte_i, CH_HASH);

  assign code_times_ten = {code_q[4:0], 3'b000} + {code_q[6:0], 1'b0};
  assign code_ok = (code_q < NUM_CODES) && enabled_codes_i[code_q[2:0]];
  assign len_cnt = (count_q >= CntW'(2)) ? count_q - CntW'(2) : '0;

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    tail_d  = tail_q;
    code_d  = code_q;
    hex_d   = hex_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    bank_d  = bank_q;
    push_o  = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.bank = bank_q;
    wr_o.idx  = IDX_W'(count_q);
    wr_o.data = rx_byte_i;
    job_o.bank = bank_q;
    job_o.code = code_q[2:0];
    job_o.hex  = hex_q;
    job_o.len  = IDX_W'(len_cnt);
    if (ovf_q) begin
      job_o.kind = ST_OVF;
    end else if (len_cnt == '0) begin
      job_o.kind = ST_EMPTY;
    end else begin
      job_o.kind = ST_DATA;
    end
    if (accept) begin
      case (phase_q)
        PH_CODE: begin
          if (rx_byte_i == CH_AT) begin
            phase_d = PH_DATA;
            tail_d  = 2'd0;
            count_d = '0;
            ovf_d   = 1'b0;
            hex_d   = 1'b0;
          end else if (tail_m.done) begin
            phase_d = PH_HUNT;
            hdr_d   = 2'd0;
            tail_d  = tail_m.prog;
          end else begin
            tail_d = tail_m.prog;
            code_d = code_times_ten + rx_byte_i - CH_ZERO;
          end
        end
        PH_DATA: begin
          tail_d = tail_m.prog;
          if (tail_m.done) begin
            phase_d = PH_HUNT;
            hdr_d   = 2'd0;
            if (code_ok) begin
              push_o = 1'b1;
              bank_d = !bank_q;
            end
          end else if (count_q < CntW'(StoreDepth)) begin
            if (count_q == '0) begin
              hex_d = is_hex(rx_byte_i);
            end
            wr_o.en = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          hdr_d   = hdr_m.prog;
          if (hdr_m.done) begin
            phase_d = PH_CODE;
            code_d  = 8'd0;
            tail_d  = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      hdr_q   <= 2'd0;
      tail_q  <= 2'd0;
      code_q  <= 8'd0;
      hex_q   <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      tail_q  <= tail_d;
      code_q  <= code_d;
      hex_q   <= hex_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
    end
  end

endmodule

// ===== design/acfd_queue.sv =====
// Two-entry queue of finished frames between front and back end.
module acfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  acfd_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output acfd_pkg::job_t job_o
);
  import acfd_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("frame pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("frame popped from an empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not follow a push");
`endif

endmodule

// ===== design/acfd_back.sv =====
// Back end: banked payload store, hex decoding and record output.
module acfd_back #(
  parameter int unsigned StoreDepth = 66
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  acfd_pkg::wr_t  wr_i,
  input  logic           job_valid_i,
  input  acfd_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     proto_code_o,
  output logic [7:0]     data_byte_o,
  output logic [1:0]     status_o,
  output logic           hex_decoded_o,
  output logic           last_o
);
  import acfd_pkg::*;

  localparam int unsigned AddrW = $clog2(StoreDepth);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_USE  = 3'b100
  } state_e;

  function automatic logic [7:0] nibble(logic [7:0] c);
    logic [7:0] n;
    n = c;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n = c - CH_ZERO;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      n = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      n = c - CH_UC_A + 8'd10;
    end
    return n;
  endfunction

  logic [7:0] mem_q [2][StoreDepth];
  logic [7:0] rd_data_q;
  logic       rd_en;

  state_e           state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [7:0]       hi_q, hi_d;

  logic       out_valid_q;
  logic [2:0] code_q;
  logic [7:0] data_q;
  status_e    status_q;
  logic       hex_q, last_q;

  logic       load;
  logic [7:0] load_data;
  status_e    load_status;
  logic       load_hex, load_last;
  logic       out_free, is_last;
  logic [7:0] rd_nib;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_i.idx[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[job_i.bank][idx_q];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = ((IDX_W'(idx_q) + IDX_W'(1)) == job_i.len);
  assign rd_nib   = nibble(rd_data_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    rd_en       = 1'b0;
    pop_o       = 1'b0;
    load        = 1'b0;
    load_data   = 8'd0;
    load_status = job_i.kind;
    load_hex    = 1'b0;
    load_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind != ST_DATA) begin
            if (out_free) begin
              load  = 1'b1;
              pop_o = 1'b1;
            end
          end else begin
            idx_d   = '0;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_USE;
      end
      S_USE: begin
        if (job_i.hex && !idx_q[0] && !is_last) begin
          // First nibble of a pair: hold it and fetch the second.
          hi_d    = rd_nib;
          idx_d   = idx_q + AddrW'(1);
          state_d = S_READ;
        end else if (out_free) begin
          load        = 1'b1;
          load_status = ST_DATA;
          load_hex    = job_i.hex;
          load_last   = is_last;
          if (!job_i.hex) begin
            load_data = rd_data_q;
          end else if (idx_q[0]) begin
            load_data = {hi_q[3:0], 4'b0000} | rd_nib;
          end else begin
            load_data = rd_nib;
          end
          if (is_last) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    if (load) begin
      code_q   <= job_i.code;
      data_q   <= load_data;
      status_q <= load_status;
      hex_q    <= load_hex;
      last_q   <= load_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign proto_code_o  = code_q;
  assign data_byte_o   = data_q;
  assign status_o      = status_q;
  assign hex_decoded_o = hex_q;
  assign last_o        = last_q;

endmodule

// ===== design/ascii_frame_deframer.sv =====
// Top level of the ASCII frame deframer: front end, frame queue and back end.
//
//  Channel   Direction  Handshake               Transaction
//  rx        in         in_valid_i/in_stall_o   one received character rx_byte_i
//  record    out        out_valid_o/out_stall_i one output record of a delivered frame
//  config    in         cfg_we_i                enabled_codes mask, write only
//
// The front end takes one character per cycle; it stalls only while two finished
// frames wait in the queue, as both payload store banks are then in use.
// The back end passes each raw byte or odd trailing nibble through a read and a use state,
// and each hex-decoded pair through two such passes (one store read port, registered read
// data); a frame with payload opens from the idle state, which emits empty or overflow records.
// Reset clears all control state; the payload store needs no clearing pass.
// A stalled output record holds in the output register while the back end waits.
module ascii_frame_deframer #(
  parameter int unsigned PAYLOAD_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] proto_code_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] status_o,
  output logic       hex_decoded_o,
  output logic       last_o
);
  import acfd_pkg::*;

  // Payload plus the two characters that might open the tail.
  localparam int unsigned StoreDepth = PAYLOAD_MAX + 2;

  logic [7:0] enabled_codes_q;
  logic       push, pop, queue_full, job_valid;
  job_t       job_in, job_head;
  wr_t        wr;

  // Hold the code mask; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_codes_q <= 8'd0;
    end else if (cfg_we_i) begin
      enabled_codes_q <= cfg_wdata_i;
    end
  end

  // Parse characters, capture payload into the current bank, push finished frames with an enabled code.
  acfd_front #(
    .StoreDepth (StoreDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .enabled_codes_i (enabled_codes_q),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .job_o           (job_in),
    .wr_o            (wr)
  );

  // Decouple parsing from emission; each entry owns one store bank.
  acfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  // Walk the head frame's bank and emit its records; drop the entry after the last.
  acfd_back #(
    .StoreDepth (StoreDepth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .proto_code_o  (proto_code_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .hex_decoded_o (hex_decoded_o),
    .last_o        (last_o)
  );

endmodule
